// ===== design/m3inv_pkg.sv =====
// Package: types, constants and cofactor index table for the 3x3 matrix inverse.
`default_nettype none
package m3inv_pkg;

   localparam int ELEMS        = 9;
   localparam int ELEM_W       = 32;
   localparam int COF_W        = 64;
   localparam int DET_W        = 98;
   localparam int DIV_STEPS    = 33;
   localparam int Q_W          = DIV_STEPS + 1;
   localparam int FRONT_STAGES = 6;
   localparam int LANE_STAGES  = DIV_STEPS + 2;
   localparam int DM_STAGES    = DIV_STEPS + 1;
   localparam int NSTG         = FRONT_STAGES + LANE_STAGES + 1;

   localparam logic [Q_W-1:0]    POS_LIMIT = Q_W'(32'h7fff_ffff);
   localparam logic [Q_W-1:0]    NEG_LIMIT = Q_W'(32'h8000_0000);
   localparam logic [ELEM_W-1:0] POS_SAT   = 32'h7fff_ffff;
   localparam logic [ELEM_W-1:0] NEG_SAT   = 32'h8000_0000;

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic signed [COF_W-1:0]  cof_type;
   typedef logic [3:0]               idx_type;

   typedef struct packed {
      logic [DET_W-1:0] dm;
      logic             dneg;
      logic             dzero;
   } m3inv_det_type;

   typedef struct packed {
      logic signed [31:0] a00;
      logic signed [31:0] a01;
      logic signed [31:0] a02;
      logic signed [31:0] a10;
      logic signed [31:0] a11;
      logic signed [31:0] a12;
      logic signed [31:0] a20;
      logic signed [31:0] a21;
      logic signed [31:0] a22;
   } m3inv_req_type;

   typedef struct packed {
      logic signed [31:0] r00;
      logic signed [31:0] r01;
      logic signed [31:0] r02;
      logic signed [31:0] r10;
      logic signed [31:0] r11;
      logic signed [31:0] r12;
      logic signed [31:0] r20;
      logic signed [31:0] r21;
      logic signed [31:0] r22;
      logic               invertible;
   } m3inv_rsp_type;

   // cofactor k = a[i0]*a[i1] - a[i2]*a[i3], elements row major
   localparam idx_type COF_IDX [ELEMS][4] = '{
      '{4'd4, 4'd8, 4'd7, 4'd5},
      '{4'd7, 4'd2, 4'd1, 4'd8},
      '{4'd1, 4'd5, 4'd4, 4'd2},
      '{4'd6, 4'd5, 4'd3, 4'd8},
      '{4'd0, 4'd8, 4'd6, 4'd2},
      '{4'd3, 4'd2, 4'd0, 4'd5},
      '{4'd3, 4'd7, 4'd6, 4'd4},
      '{4'd6, 4'd1, 4'd0, 4'd7},
      '{4'd0, 4'd4, 4'd3, 4'd1}
   };

endpackage
`default_nettype wire

// ===== design/m3inv_if.sv =====
// Interfaces: request and response valid/ready channels.
`default_nettype none
interface m3inv_req_if import m3inv_pkg::*; ();
   logic          valid;
   logic          ready;
   m3inv_req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface m3inv_rsp_if import m3inv_pkg::*; ();
   logic          valid;
   logic          ready;
   m3inv_rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== design/m3inv_front.sv =====
// Front end: input register, element products, cofactors and determinant magnitude.
`default_nettype none
module m3inv_front import m3inv_pkg::*; (
   input  wire logic                    clock,
   input  wire logic [FRONT_STAGES-1:0] load,
   input  wire elem_type                a_in [ELEMS],
   output elem_type                     a_out [ELEMS],
   output cof_type                      c_out [ELEMS],
   output m3inv_det_type                det_out
);

   elem_type          a_ff [FRONT_STAGES][ELEMS];
   cof_type           prod_ff [ELEMS][2];
   cof_type           c_ff [FRONT_STAGES-2][ELEMS];
   cof_type           ph_ff [3];
   cof_type           pl_ff [3];
   logic [DET_W-1:0]  d_ff;
   m3inv_det_type     det_ff;
   logic [DET_W-1:0]  d_in;

   // element pipeline
   always_ff @(posedge clock) begin
      if (load[0]) begin
         a_ff[0] <= a_in;
      end
      for (int s = 1; s < FRONT_STAGES; s++) begin
         if (load[s]) begin
            a_ff[s] <= a_ff[s-1];
         end
      end
   end

   // products, then cofactors
   always_ff @(posedge clock) begin
      if (load[1]) begin
         for (int k = 0; k < ELEMS; k++) begin
            prod_ff[k][0] <= a_ff[0][COF_IDX[k][0]] * a_ff[0][COF_IDX[k][1]];
            prod_ff[k][1] <= a_ff[0][COF_IDX[k][2]] * a_ff[0][COF_IDX[k][3]];
         end
      end
      if (load[2]) begin
         for (int k = 0; k < ELEMS; k++) begin
            c_ff[0][k] <= prod_ff[k][0] - prod_ff[k][1];
         end
      end
      for (int s = 3; s < FRONT_STAGES; s++) begin
         if (load[s]) begin
            c_ff[s-2] <= c_ff[s-3];
         end
      end
   end

   // determinant down column 0; cofactor split in 32-bit halves
   always_ff @(posedge clock) begin
      if (load[3]) begin
         for (int m = 0; m < 3; m++) begin
            ph_ff[m] <= a_ff[2][3*m] * $signed(c_ff[0][m][63:32]);
            pl_ff[m] <= a_ff[2][3*m] * $signed({1'b0, c_ff[0][m][31:0]});
         end
      end
   end

   always_comb begin
      d_in = '0;
      for (int m = 0; m < 3; m++) begin
         d_in = d_in + {{2{ph_ff[m][63]}}, ph_ff[m], 32'b0}
                     + {{34{pl_ff[m][63]}}, pl_ff[m]};
      end
   end

   always_ff @(posedge clock) begin
      if (load[4]) begin
         d_ff <= d_in;
      end
      if (load[5]) begin
         det_ff.dm    <= d_ff[DET_W-1] ? (~d_ff + 1'b1) : d_ff;
         det_ff.dneg  <= d_ff[DET_W-1];
         det_ff.dzero <= (d_ff == '0);
      end
   end

   assign a_out   = a_ff[FRONT_STAGES-1];
   assign c_out   = c_ff[FRONT_STAGES-3];
   assign det_out = det_ff;

endmodule
`default_nettype wire

// ===== design/m3inv_lane.sv =====
// Divider lane: pipelined restoring division of one cofactor by the determinant.
`default_nettype none
module m3inv_lane import m3inv_pkg::*; (
   input  wire logic                   clock,
   input  wire logic [LANE_STAGES-1:0] load,
   input  wire cof_type                c_in,
   input  wire m3inv_det_type          det_in,
   input  wire logic [DET_W-1:0]       dm_in [DM_STAGES],
   output logic [ELEM_W-1:0]           q_out
);

   logic [DET_W-1:0]     r_ff [DM_STAGES];
   logic [DIV_STEPS-1:0] q_ff [DM_STAGES];
   logic                 neg_ff [DM_STAGES];
   logic                 ovf_ff [DM_STAGES];
   logic                 nb_ff;
   logic [ELEM_W-1:0]    q_out_ff;

   logic [COF_W-1:0]     cm;
   logic [DET_W-1:0]     r_init;
   logic                 rup;
   logic [Q_W-1:0]       q_rnd;
   logic [Q_W-1:0]       q_neg;

   // quotient < 2^33 unless overflow, so the remainder starts at |c| >> 1
   assign cm     = c_in[COF_W-1] ? (~c_in + 1'b1) : c_in;
   assign r_init = {{(DET_W-COF_W+1){1'b0}}, cm[COF_W-1:1]};

   always_ff @(posedge clock) begin
      if (load[0]) begin
         r_ff[0]   <= r_init;
         q_ff[0]   <= '0;
         nb_ff     <= cm[0];
         neg_ff[0] <= c_in[COF_W-1] ^ det_in.dneg;
         ovf_ff[0] <= (r_init >= det_in.dm);
      end
   end

   for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_step
      logic             nbit;
      logic [DET_W:0]   rs;
      logic [DET_W:0]   dd;
      logic             ge;
      logic [DET_W:0]   diff;

      assign nbit = (j == 1) ? nb_ff : 1'b0;
      assign rs   = {r_ff[j-1], nbit};
      assign dd   = {1'b0, dm_in[j-1]};
      assign ge   = (rs >= dd);
      assign diff = rs - dd;

      always_ff @(posedge clock) begin
         if (load[j]) begin
            r_ff[j]   <= ge ? diff[DET_W-1:0] : rs[DET_W-1:0];
            q_ff[j]   <= {q_ff[j-1][DIV_STEPS-2:0], ge};
            neg_ff[j] <= neg_ff[j-1];
            ovf_ff[j] <= ovf_ff[j-1];
         end
      end
   end

   // round half away from zero on the magnitude, then saturate
   assign rup   = ({r_ff[DIV_STEPS], 1'b0} >= {1'b0, dm_in[DIV_STEPS]});
   assign q_rnd = {1'b0, q_ff[DIV_STEPS]} + Q_W'(rup);
   assign q_neg = ~q_rnd + 1'b1;

   always_ff @(posedge clock) begin
      if (load[LANE_STAGES-1]) begin
         if (neg_ff[DIV_STEPS]) begin
            if (ovf_ff[DIV_STEPS] || (q_rnd > NEG_LIMIT)) begin
               q_out_ff <= NEG_SAT;
            end else begin
               q_out_ff <= q_neg[ELEM_W-1:0];
            end
         end else begin
            if (ovf_ff[DIV_STEPS] || (q_rnd > POS_LIMIT)) begin
               q_out_ff <= POS_SAT;
            end else begin
               q_out_ff <= q_rnd[ELEM_W-1:0];
            end
         end
      end
   end

   assign q_out = q_out_ff;

endmodule
`default_nettype wire

// ===== design/matrix3x3_inverse.sv =====
// Top level: 3x3 Q16.16 matrix inverse by adjugate, nine divider lanes and merge.
//
// Usage notes:
//  - req_ch carries one whole matrix (a00..a22, signed Q16.16) per transfer.
//  - rsp_ch returns one result per request, in order: r00..r22 and invertible.
//    invertible=1: r is adj/det rounded (ties away from zero), saturated to Q16.16.
//    invertible=0: determinant was exactly zero, r is the input matrix as-is.
//  - Pipeline: a request passes 6 front stages, 35 lane stages and 1 output
//    register; rsp valid rises when the result reaches the output register.
//  - Throughput: one matrix per cycle while rsp ready stays high. Rate is
//    set by the 33 pipelined divide steps per lane, one quotient bit per
//    stage, 9 lanes side by side.
//  - Each stage has its own valid bit; a stage loads when empty or when the
//    stage after it moves, so bubbles collapse and the front keeps taking
//    requests while a result waits in the output register.
//  - Receiver stall: the output register holds; stages fill up behind it,
//    and req ready drops only once every stage holds a matrix.
//  - Reset (synchronous, active high) clears all valid bits; data regs are
//    not reset.
`default_nettype none
module matrix3x3_inverse import m3inv_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   m3inv_req_if.sink    req_ch,
   m3inv_rsp_if.source  rsp_ch
);

   logic [NSTG-1:0]   vld_ff;
   logic [NSTG:0]     rdy;

   elem_type          a_in [ELEMS];
   elem_type          a_front [ELEMS];
   cof_type           c_front [ELEMS];
   m3inv_det_type     det_front;

   logic [DET_W-1:0]  dm_ff [DM_STAGES];
   elem_type          pass_a_ff [LANE_STAGES][ELEMS];
   logic              pass_z_ff [LANE_STAGES];
   logic [ELEM_W-1:0] lane_q [ELEMS];
   m3inv_rsp_type     rsp_ff;
   m3inv_rsp_type     rsp_in;

   // stage control: load when empty or when the next stage moves
   assign rdy[NSTG] = rsp_ch.ready;
   for (genvar i = 0; i < NSTG; i++) begin : g_rdy
      assign rdy[i] = !vld_ff[i] || rdy[i+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[0]) begin
            vld_ff[0] <= req_ch.valid;
         end
         for (int i = 1; i < NSTG; i++) begin
            if (rdy[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   assign req_ch.ready = rdy[0];

   assign a_in[0] = req_ch.payload.a00;
   assign a_in[1] = req_ch.payload.a01;
   assign a_in[2] = req_ch.payload.a02;
   assign a_in[3] = req_ch.payload.a10;
   assign a_in[4] = req_ch.payload.a11;
   assign a_in[5] = req_ch.payload.a12;
   assign a_in[6] = req_ch.payload.a20;
   assign a_in[7] = req_ch.payload.a21;
   assign a_in[8] = req_ch.payload.a22;

   m3inv_front u_front (
      .clock   (clock),
      .load    (rdy[FRONT_STAGES-1:0]),
      .a_in    (a_in),
      .a_out   (a_front),
      .c_out   (c_front),
      .det_out (det_front)
   );

   // divisor and pass-through data ride alongside the lanes
   always_ff @(posedge clock) begin
      if (rdy[FRONT_STAGES]) begin
         dm_ff[0]     <= det_front.dm;
         pass_a_ff[0] <= a_front;
         pass_z_ff[0] <= det_front.dzero;
      end
      for (int s = 1; s < DM_STAGES; s++) begin
         if (rdy[FRONT_STAGES+s]) begin
            dm_ff[s] <= dm_ff[s-1];
         end
      end
      for (int s = 1; s < LANE_STAGES; s++) begin
         if (rdy[FRONT_STAGES+s]) begin
            pass_a_ff[s] <= pass_a_ff[s-1];
            pass_z_ff[s] <= pass_z_ff[s-1];
         end
      end
   end

   for (genvar k = 0; k < ELEMS; k++) begin : g_lane
      m3inv_lane u_lane (
         .clock  (clock),
         .load   (rdy[FRONT_STAGES +: LANE_STAGES]),
         .c_in   (c_front[k]),
         .det_in (det_front),
         .dm_in  (dm_ff),
         .q_out  (lane_q[k])
      );
   end

   // merge: lane quotients, or the input matrix when singular
   always_comb begin
      if (pass_z_ff[LANE_STAGES-1]) begin
         rsp_in.r00 = pass_a_ff[LANE_STAGES-1][0];
         rsp_in.r01 = pass_a_ff[LANE_STAGES-1][1];
         rsp_in.r02 = pass_a_ff[LANE_STAGES-1][2];
         rsp_in.r10 = pass_a_ff[LANE_STAGES-1][3];
         rsp_in.r11 = pass_a_ff[LANE_STAGES-1][4];
         rsp_in.r12 = pass_a_ff[LANE_STAGES-1][5];
         rsp_in.r20 = pass_a_ff[LANE_STAGES-1][6];
         rsp_in.r21 = pass_a_ff[LANE_STAGES-1][7];
         rsp_in.r22 = pass_a_ff[LANE_STAGES-1][8];
      end else begin
         rsp_in.r00 = lane_q[0];
         rsp_in.r01 = lane_q[1];
         rsp_in.r02 = lane_q[2];
         rsp_in.r10 = lane_q[3];
         rsp_in.r11 = lane_q[4];
         rsp_in.r12 = lane_q[5];
         rsp_in.r20 = lane_q[6];
         rsp_in.r21 = lane_q[7];
         rsp_in.r22 = lane_q[8];
      end
      rsp_in.invertible = !pass_z_ff[LANE_STAGES-1];
   end

   always_ff @(posedge clock) begin
      if (rdy[NSTG-1]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid   = vld_ff[NSTG-1];
   assign rsp_ch.payload = rsp_ff;

endmodule
`default_nettype wire
